@@ src/swtm_pkg.sv @@
// Shared types and constants for the sliding window trimmed mean unit.
`default_nettype none
package swtm_pkg;
   localparam int unsigned CFG_IDX_BITS = 8;
   localparam int unsigned CFG_DATA_BITS = 32;
   localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 8'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_COUNT = 8'd1;
   localparam logic [6:0] WINDOW_LENGTH_RESET = 7'd16;
   localparam logic [4:0] TRIM_COUNT_RESET = 5'd2;
   localparam logic [6:0] MIN_WINDOW = 7'd3;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_FIND,
      BE_SHIFT,
      BE_SUM,
      BE_DIV,
      BE_DONE
   } be_state_type;
endpackage
`default_nettype wire

@@ src/sliding_window_trimmed_mean_unit.sv @@
// Sliding window trimmed mean unit: top level, configuration and assertions.
// One sample at a time. The front end writes the arrival ring and hands the
// new and evicted values to the back end through a one-entry queue. The back
// end scans the sorted store for the evicted value one entry per cycle, moves
// entries, each by a read and then a write, to place the new one, and, when
// the window is full, reads the 2*trim trimmed entries and then runs a
// bit-serial divider. The back end does not start the next sample while a
// result is still waiting. A configuration write to the window length or
// trim count register empties the window.
`default_nettype none
module sliding_window_trimmed_mean_unit import swtm_pkg::*; #(
   parameter int unsigned MAX_WINDOW = 64,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [SAMPLE_BITS-1:0]   req_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_mean_valid,
   output logic [SAMPLE_BITS-1:0]        rsp_trimmed_mean,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CFG_IDX_BITS-1:0]  csr_index,
   input  wire logic [CFG_DATA_BITS-1:0] csr_data
);
   localparam int unsigned LEN_BITS = $clog2(MAX_WINDOW + 1) > 7 ? $clog2(MAX_WINDOW + 1) : 7;
   localparam int unsigned SUM_BITS = SAMPLE_BITS + LEN_BITS;

   logic [6:0] wlen_ff, wlen_in;
   logic [4:0] trim_ff, trim_in;
   logic       clear;
   logic [LEN_BITS-1:0] eff_len, eff_trim, tmax, wl_ext, tr_ext;
   logic q_valid, q_ready, q_evict, q_full;
   logic [SAMPLE_BITS-1:0] q_new, q_old;

   assign csr_ready = 1'b1;
   assign clear = csr_valid && csr_ready &&
                  (csr_index == REG_WINDOW_LENGTH || csr_index == REG_TRIM_COUNT);

   always_comb begin
      wlen_in = wlen_ff;
      trim_in = trim_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW_LENGTH: wlen_in = csr_data[6:0];
            REG_TRIM_COUNT:    trim_in = csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WINDOW_LENGTH_RESET;
         trim_ff <= TRIM_COUNT_RESET;
      end else begin
         wlen_ff <= wlen_in;
         trim_ff <= trim_in;
      end
   end

   assign wl_ext = LEN_BITS'(wlen_ff);
   assign tr_ext = LEN_BITS'(trim_ff);
   always_comb begin
      eff_len = wl_ext;
      if (wl_ext < LEN_BITS'(MIN_WINDOW)) eff_len = LEN_BITS'(MIN_WINDOW);
      if (wl_ext > LEN_BITS'(MAX_WINDOW)) eff_len = LEN_BITS'(MAX_WINDOW);
      tmax = (eff_len - LEN_BITS'(1)) >> 1;
      eff_trim = (tr_ext > tmax) ? tmax : tr_ext;
   end

   swtm_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .LEN_BITS(LEN_BITS))
   u_front (
      .clock(clock), .reset(reset), .clear(clear), .eff_len(eff_len),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .q_valid(q_valid), .q_ready(q_ready), .q_new(q_new), .q_old(q_old),
      .q_evict(q_evict), .q_full(q_full)
   );

   swtm_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS),
               .LEN_BITS(LEN_BITS), .SUM_BITS(SUM_BITS))
   u_back (
      .clock(clock), .reset(reset), .clear(clear), .eff_len(eff_len),
      .eff_trim(eff_trim), .q_valid(q_valid), .q_ready(q_ready), .q_new(q_new),
      .q_old(q_old), .q_evict(q_evict), .q_full(q_full),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mean_valid(rsp_mean_valid), .rsp_trimmed_mean(rsp_trimmed_mean)
   );

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mean_valid |-> rsp_trimmed_mean == '0)
      else $error("mean not zero while window not full");
   a_trim_fits: assert property (@(posedge clock) disable iff (reset)
      (eff_trim << 1) < eff_len)
      else $error("trim leaves no sample");
   a_q_ready_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> q_valid)
      else $error("back end took a queue entry that was not there");
endmodule
`default_nettype wire

@@ src/swtm_front.sv @@
// Front end: accepts samples, keeps the arrival ring, finds the evicted value.
`default_nettype none
module swtm_front import swtm_pkg::*; #(
   parameter int unsigned MAX_WINDOW = 64,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned LEN_BITS = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   clear,
   input  wire logic [LEN_BITS-1:0]    eff_len,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        q_valid,
   input  wire logic                   q_ready,
   output logic [SAMPLE_BITS-1:0]      q_new,
   output logic [SAMPLE_BITS-1:0]      q_old,
   output logic                        q_evict,
   output logic                        q_full
);
   localparam int unsigned PTR_BITS = $clog2(MAX_WINDOW);

   logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [PTR_BITS-1:0]    wp_ff, wp_in;
   logic [LEN_BITS-1:0]    fill_ff, fill_in;
   logic                   busy_ff, busy_in;
   logic                   evict_ff, evict_in;
   logic                   full_ff, full_in;
   logic [SAMPLE_BITS-1:0] new_ff;
   logic [SAMPLE_BITS-1:0] old_ff;
   logic                   accept;
   logic [PTR_BITS-1:0]    wp_use;
   logic [LEN_BITS-1:0]    wp_ext;

   assign req_ready = !busy_ff;
   assign accept = req_valid && req_ready;
   assign wp_ext = LEN_BITS'(wp_ff);
   assign wp_use = (wp_ext >= eff_len) ? '0 : wp_ff;

   always_comb begin
      wp_in = wp_ff;
      fill_in = fill_ff;
      busy_in = busy_ff;
      evict_in = evict_ff;
      full_in = full_ff;
      if (accept) begin
         busy_in = 1'b1;
         evict_in = (fill_ff >= eff_len);
         full_in = (fill_ff + LEN_BITS'(1) >= eff_len);
         if (fill_ff < eff_len) begin
            fill_in = fill_ff + LEN_BITS'(1);
         end
         if (LEN_BITS'(wp_use) + LEN_BITS'(1) >= eff_len) begin
            wp_in = '0;
         end else begin
            wp_in = wp_use + PTR_BITS'(1);
         end
      end else if (busy_ff && q_ready) begin
         busy_in = 1'b0;
      end
      if (clear) begin
         wp_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fill_ff <= '0;
         busy_ff <= 1'b0;
         evict_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         busy_ff <= busy_in;
         evict_ff <= evict_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wp_use] <= req_sample;
         old_ff <= ring_mem[wp_use];
         new_ff <= req_sample;
      end
   end

   assign q_valid = busy_ff;
   assign q_new = new_ff;
   assign q_old = old_ff;
   assign q_evict = evict_ff;
   assign q_full = full_ff;
endmodule
`default_nettype wire

@@ src/swtm_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swtm_divider #(
   parameter int unsigned NUM_BITS = 22,
   parameter int unsigned DEN_BITS = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numer,
   input  wire logic [DEN_BITS-1:0] denom,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quot
);
   localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS-1:0] r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff, d_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[NUM_BITS-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CNT_BITS'(NUM_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DEN_BITS'(trial - {1'b0, d_ff});
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = DEN_BITS'(trial);
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

@@ src/swtm_back.sv @@
// Back end: sorted store update, trimmed sums, division and result register.
`default_nettype none
module swtm_back import swtm_pkg::*; #(
   parameter int unsigned MAX_WINDOW = 64,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned LEN_BITS = 7,
   parameter int unsigned SUM_BITS = 22
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   clear,
   input  wire logic [LEN_BITS-1:0]    eff_len,
   input  wire logic [LEN_BITS-1:0]    eff_trim,
   input  wire logic                   q_valid,
   output logic                        q_ready,
   input  wire logic [SAMPLE_BITS-1:0] q_new,
   input  wire logic [SAMPLE_BITS-1:0] q_old,
   input  wire logic                   q_evict,
   input  wire logic                   q_full,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_mean_valid,
   output logic [SAMPLE_BITS-1:0]      rsp_trimmed_mean
);
   localparam int unsigned PTR_BITS = $clog2(MAX_WINDOW);

   be_state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sort_mem [MAX_WINDOW];
   logic [LEN_BITS-1:0]    n_ff, n_in;
   logic [LEN_BITS-1:0]    idx_ff, idx_in;
   logic [LEN_BITS-1:0]    hole_ff, hole_in;
   logic [LEN_BITS-1:0]    ins_ff, ins_in;
   logic [SUM_BITS-1:0]    wsum_ff, wsum_in;
   logic [SUM_BITS-1:0]    acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [LEN_BITS-1:0]    rd_addr;
   logic                   rd_en;
   logic                   wr_en;
   logic [LEN_BITS-1:0]    wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic                   rvalid_ff, rvalid_in;
   logic                   mvalid_ff, mvalid_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic                   div_start;
   logic                   div_done;
   logic [SUM_BITS-1:0]    div_quot;
   logic [LEN_BITS-1:0]    div_den;
   logic                   pend_ff, pend_in;
   logic                   rd_pend_ff;

   // Sorted store, one read and one write port. Sequence per item:
   // FIND scans for the evicted value (its hole), SHIFT moves entries, each by a
   // read and then a write, to open the insert slot, SUM walks the trimmed ends.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sort_mem[wr_addr[PTR_BITS-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= sort_mem[rd_addr[PTR_BITS-1:0]];
      end
   end

   assign div_den = eff_len - (eff_trim << 1);

   swtm_divider #(.NUM_BITS(SUM_BITS), .DEN_BITS(LEN_BITS)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(wsum_ff - acc_ff),
      .denom(div_den),
      .done(div_done),
      .quot(div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE:  if (q_valid && !rvalid_ff) state_in = BE_FIND;
         BE_FIND: begin
            if (!q_evict || (rd_pend_ff && rd_ff == q_old) || idx_ff >= n_ff) begin
               state_in = BE_SHIFT;
            end
         end
         BE_SHIFT: if (pend_ff == 1'b0 && ins_ff != '0 && idx_ff == '1) state_in = BE_SUM;
         BE_SUM:   if (idx_ff == '1) state_in = q_full ? BE_DIV : BE_DONE;
         BE_DIV:   if (div_done) state_in = BE_DONE;
         BE_DONE:  state_in = BE_IDLE;
         default:  state_in = BE_IDLE;
      endcase
   end

   // Datapath and outputs per state.
   always_comb begin
      n_in = n_ff;
      idx_in = idx_ff;
      hole_in = hole_ff;
      ins_in = ins_ff;
      wsum_in = wsum_ff;
      acc_in = acc_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = q_new;
      rvalid_in = rvalid_ff;
      mvalid_in = mvalid_ff;
      mean_in = mean_ff;
      div_start = 1'b0;
      pend_in = pend_ff;
      q_ready = 1'b0;
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         BE_IDLE: begin
            idx_in = '0;
            ins_in = '0;
            pend_in = 1'b0;
            if (q_valid && !rvalid_ff) begin
               rd_en = 1'b1;
               rd_addr = '0;
               idx_in = LEN_BITS'(1);
            end
         end
         BE_FIND: begin
            // idx_ff is one past the address whose data is in rd_ff
            if (!q_evict || idx_ff > n_ff) begin
               hole_in = n_ff;
               n_in = n_ff;
               if (q_evict) n_in = n_ff;
            end else if (rd_ff == q_old) begin
               hole_in = idx_ff - LEN_BITS'(1);
            end else begin
               rd_en = 1'b1;
               idx_in = idx_ff + LEN_BITS'(1);
            end
            if (state_in == BE_SHIFT) begin
               // after removal the list is n-1 long with a hole at hole_in
               if (!q_evict) begin
                  hole_in = n_ff;
                  n_in = n_ff + LEN_BITS'(1);
               end
               idx_in = '0;
               pend_in = 1'b0;
               wsum_in = wsum_ff - (q_evict ? SUM_BITS'(q_old) : '0) + SUM_BITS'(q_new);
            end
         end
         BE_SHIFT: begin
            // Move the hole toward the insert position, one step per read and write.
            if (!pend_ff) begin
               if (hole_ff > '0 && idx_ff == '0) begin
                  rd_en = 1'b1;
                  rd_addr = hole_ff - LEN_BITS'(1);
                  pend_in = 1'b1;
               end else if (idx_ff == '0) begin
                  idx_in = LEN_BITS'(1);
               end else if (hole_ff + LEN_BITS'(1) < n_ff && idx_ff == LEN_BITS'(1)) begin
                  rd_en = 1'b1;
                  rd_addr = hole_ff + LEN_BITS'(1);
                  pend_in = 1'b1;
               end else if (ins_ff == '0) begin
                  wr_en = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = q_new;
                  ins_in = LEN_BITS'(1);
                  idx_in = '1;
               end
            end else begin
               pend_in = 1'b0;
               if (idx_ff == '0) begin
                  if (rd_ff > q_new) begin
                     wr_en = 1'b1;
                     wr_addr = hole_ff;
                     wr_data = rd_ff;
                     hole_in = hole_ff - LEN_BITS'(1);
                  end else begin
                     idx_in = LEN_BITS'(1);
                  end
               end else begin
                  if (rd_ff < q_new) begin
                     wr_en = 1'b1;
                     wr_addr = hole_ff;
                     wr_data = rd_ff;
                     hole_in = hole_ff + LEN_BITS'(1);
                  end else begin
                     idx_in = LEN_BITS'(2);
                  end
               end
            end
            if (state_in == BE_SUM) begin
               idx_in = '0;
               acc_in = '0;
               pend_in = 1'b0;
            end
         end
         BE_SUM: begin
            // idx counts reads over the low then the high trimmed entries
            if (!q_full) begin
               idx_in = '1;
            end else if (pend_ff) begin
               acc_in = acc_ff + SUM_BITS'(rd_ff);
               pend_in = 1'b0;
               idx_in = idx_ff + LEN_BITS'(1);
               if (idx_ff + LEN_BITS'(1) >= (eff_trim << 1)) begin
                  idx_in = '1;
               end
            end else if ((eff_trim << 1) == '0) begin
               idx_in = '1;
            end else begin
               rd_en = 1'b1;
               rd_addr = (idx_ff < eff_trim) ? idx_ff
                       : n_ff - LEN_BITS'(1) - (idx_ff - eff_trim);
               pend_in = 1'b1;
            end
            if (state_in == BE_DIV) begin
               div_start = 1'b1;
            end
         end
         BE_DIV: begin
            if (div_done) begin
               mean_in = div_quot[SAMPLE_BITS-1:0];
            end
         end
         BE_DONE: begin
            q_ready = 1'b1;
            rvalid_in = 1'b1;
            mvalid_in = q_full;
            if (!q_full) mean_in = '0;
         end
         default: begin
         end
      endcase
      if (clear) begin
         n_in = '0;
         wsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         n_ff <= '0;
         wsum_ff <= '0;
         rvalid_ff <= 1'b0;
         pend_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         wsum_ff <= wsum_in;
         rvalid_ff <= rvalid_in;
         pend_ff <= pend_in;
         rd_pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hole_ff <= hole_in;
      ins_ff <= ins_in;
      acc_ff <= acc_in;
      mvalid_ff <= mvalid_in;
      mean_ff <= mean_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_mean_valid = mvalid_ff;
   assign rsp_trimmed_mean = mean_ff;
endmodule
`default_nettype wire

@@ verif/sliding_window_trimmed_mean_unit_test.sv @@
// Testbench for the sliding window trimmed mean unit: random traffic checked against a window model.
`default_nettype none
module sliding_window_trimmed_mean_unit_test;
   import swtm_pkg::*;

   localparam int DRAIN_CYCLES = 450;

   typedef struct packed {
      logic        mean_valid;
      logic [15:0] trimmed_mean;
   } mean_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_mean_valid;
   logic [15:0] rsp_trimmed_mean;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_DATA_BITS-1:0] csr_data = '0;

   sliding_window_trimmed_mean_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // window model
   logic [6:0] win_len_reg;
   logic [4:0] trim_reg;
   logic [15:0] ring_mem [64];
   logic [15:0] sorted_mem [64];
   int unsigned fill_cnt, wr_ptr, win_sum;

   logic [15:0] sample_q [$];
   mean_rsp_type mean_q [$];
   int errors = 0;
   bit req_took = 1'b0;
   bit steady = 1'b0;
   int hold_left = 0;

   function automatic void queue_sample(logic [15:0] v);
      sample_q.insert(sample_q.size(), v);
   endfunction

   function automatic void window_clear();
      fill_cnt = 0;
      wr_ptr = 0;
      win_sum = 0;
   endfunction

   function automatic void sorted_insert(logic [15:0] v);
      int unsigned pos;
      pos = fill_cnt;
      while (pos > 0 && sorted_mem[pos-1] > v) begin
         sorted_mem[pos] = sorted_mem[pos-1];
         pos--;
      end
      sorted_mem[pos] = v;
   endfunction

   function automatic void sorted_remove(logic [15:0] v, int unsigned n);
      int unsigned i;
      i = 0;
      while (i < n && sorted_mem[i] != v) i++;
      if (i < n) begin
         while (i + 1 < n) begin
            sorted_mem[i] = sorted_mem[i+1];
            i++;
         end
      end
   endfunction

   function automatic mean_rsp_type window_mean(logic [15:0] s);
      int unsigned len, p, t, lo, hi, i;
      logic [15:0] old;
      mean_rsp_type r;
      len = win_len_reg < 3 ? 3 : (win_len_reg > 64 ? 64 : win_len_reg);
      p = wr_ptr;
      if (p >= len) p = 0;
      if (fill_cnt < len) begin
         sorted_insert(s);
         fill_cnt++;
         win_sum += s;
      end else begin
         old = ring_mem[p];
         sorted_remove(old, fill_cnt);
         fill_cnt--;
         sorted_insert(s);
         fill_cnt++;
         win_sum = win_sum - old + s;
      end
      ring_mem[p] = s;
      p++;
      if (p >= len) p = 0;
      wr_ptr = p;
      r = '0;
      if (fill_cnt >= len) begin
         t = trim_reg > (len - 1) / 2 ? (len - 1) / 2 : trim_reg;
         lo = 0;
         hi = 0;
         for (i = 0; i < t; i++) begin
            lo += sorted_mem[i];
            hi += sorted_mem[len-1-i];
         end
         r.mean_valid = 1'b1;
         r.trimmed_mean = 16'((win_sum - lo - hi) / (len - 2 * t));
      end
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   // monitor: transfers on all three channels
   always @(posedge clock) begin
      mean_rsp_type want;
      req_took = req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WINDOW_LENGTH) begin
               win_len_reg = csr_data[6:0];
               window_clear();
            end else if (csr_index == REG_TRIM_COUNT) begin
               trim_reg = csr_data[4:0];
               window_clear();
            end
         end
         if (req_took) mean_q.insert(mean_q.size(), window_mean(req_sample));
         if (rsp_valid && rsp_ready) begin
            if (mean_q.size() == 0) begin
               report("unexpected result", rsp_trimmed_mean, 0);
            end else begin
               want = mean_q.pop_front();
               if (rsp_mean_valid !== want.mean_valid)
                  report("mean_valid", rsp_mean_valid, want.mean_valid);
               if (rsp_trimmed_mean !== want.trimmed_mean)
                  report("trimmed_mean", rsp_trimmed_mean, want.trimmed_mean);
            end
         end
      end
   end

   // sample driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_took) begin
         end else if (sample_q.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
            req_sample <= sample_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= steady || $urandom_range(99) >= 28;
         end
      end
   end

   task automatic drain();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || mean_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(int len, int trim);
      csr_write(REG_WINDOW_LENGTH, {$urandom} & ~32'h7f | 32'(len));
      csr_write(REG_TRIM_COUNT, {$urandom} & ~32'h1f | 32'(trim));
   endtask

   task automatic push_random(int n, bit narrow);
      repeat (n) begin
         if (narrow) queue_sample(16'($urandom_range(3)));
         else if ($urandom_range(9) == 0) queue_sample($urandom_range(1) ? 16'hffff : 16'h0);
         else queue_sample(16'($urandom));
      end
   endtask

   initial begin
      int len, trim, n, total;
      win_len_reg = WINDOW_LENGTH_RESET;
      trim_reg = TRIM_COUNT_RESET;
      window_clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings, extremes and duplicates
      for (int i = 0; i < 8; i++) queue_sample(i[0] ? 16'hffff : 16'h0);
      repeat (10) queue_sample(16'h1234);
      set_window(0, 1);
      for (int i = 0; i < 4; i++) queue_sample(16'hffff);
      set_window(127, 31);
      push_random(3, 0);
      // unknown index keeps the window
      csr_write(8'd2 + 8'($urandom_range(253)), $urandom);
      push_random(4, 0);
      set_window(64, 0);
      set_window(3, 31);

      // long receiver hold-off with a steady sender
      steady = 1'b1;
      @(posedge clock);
      hold_left = 600;
      push_random(60, 0);
      drain();
      steady = 1'b0;

      total = 0;
      while (total < 1520) begin
         if ($urandom_range(9) < 8) len = $urandom_range(12, 3);
         else len = $urandom_range(1) ? 64 : $urandom_range(127);
         trim = $urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(4);
         if ($urandom_range(7) == 0) begin
            csr_write($urandom_range(1) ? REG_TRIM_COUNT : REG_WINDOW_LENGTH,
                      $urandom_range(1) ? 32'(trim) : 32'(len));
         end else begin
            set_window(len, trim);
         end
         n = $urandom_range(80, 20);
         if (total > 700 && total < 900) steady = 1'b1;
         push_random(n, $urandom_range(4) == 0);
         total += n;
         if (steady || $urandom_range(5) == 0) drain();
         steady = 1'b0;
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && mean_q.size() == 0)
         $display("sliding_window_trimmed_mean_unit test passed");
      else
         $display("sliding_window_trimmed_mean_unit test failed");
      $finish;
   end

   initial begin
      #40000000;
      $display("sliding_window_trimmed_mean_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire
